>>> sv/pfpb_pkg.sv
package pfpb_pkg;

    localparam int DEPTH       = 16;
    localparam int HANDLE_BITS = 16;

    // Stored handle bits: the port is 16 bits wide, so no more than that survive.
    localparam int HB_W    = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
    localparam int LEN_W   = 16;
    localparam int ADDR_W  = 32;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TOT_W   = $clog2(DEPTH * 65535 + 1);
    localparam int CLIM_W  = 5;
    localparam int BLIM_W  = 20;
    localparam int CCMP_W  = (CNT_W > CLIM_W) ? CNT_W : CLIM_W;
    localparam int BCMP_W  = (TOT_W > BLIM_W) ? TOT_W : BLIM_W;
    localparam int ENT_W   = HB_W + ADDR_W + LEN_W;
    localparam int SLOT_W  = 5;

    localparam logic [1:0] REQ_ENQUEUE = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_DROP    = 2'd2;

    localparam logic [1:0] DISP_FORCED   = 2'd0;
    localparam logic [1:0] DISP_RELEASED = 2'd1;
    localparam logic [1:0] DISP_DROPPED  = 2'd2;

    localparam logic [1:0] REG_COUNT_ON  = 2'd0;
    localparam logic [1:0] REG_COUNT_LIM = 2'd1;
    localparam logic [1:0] REG_BYTE_ON   = 2'd2;
    localparam logic [1:0] REG_BYTE_LIM  = 2'd3;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic [HB_W-1:0]   handle;
        logic [ADDR_W-1:0] dest;
        logic [LEN_W-1:0]  len;
    } t_entry;

    typedef struct packed {
        logic              count_on;
        logic [CLIM_W-1:0] count_lim;
        logic              byte_on;
        logic [BLIM_W-1:0] byte_lim;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE_RD,
        ST_PRE_TAKE,
        ST_APPEND,
        ST_CHECK,
        ST_EV_RD,
        ST_EV_TAKE,
        ST_FL_RD,
        ST_FL_CHK,
        ST_FL_END,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic sel_scan;
        logic evict_take;
        logic append;
        logic scan_init;
        logic scan_match;
        logic scan_keep;
        logic scan_next;
        logic scan_end;
        logic flush_out;
    } t_cmd;

    typedef struct packed {
        t_cnt count;
        logic full;
        logic over;
        logic scan_done;
        logic match;
        logic take_ok;
        logic out_free;
        logic pend_v;
    } t_status;

endpackage

>>> sv/pfpb_ram.sv
module pfpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/pfpb_cfg.sv
module pfpb_cfg
    import pfpb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg        r_cfg;
    logic        w_wr;
    logic [1:0]  w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count_on  <= 1'b0;
            r_cfg.count_lim <= CLIM_W'(16);
            r_cfg.byte_on   <= 1'b0;
            r_cfg.byte_lim  <= '1;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_COUNT_ON:  r_cfg.count_on  <= pwdata[0];
                REG_COUNT_LIM: r_cfg.count_lim <= pwdata[CLIM_W-1:0];
                REG_BYTE_ON:   r_cfg.byte_on   <= pwdata[0];
                REG_BYTE_LIM:  r_cfg.byte_lim  <= pwdata[BLIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_COUNT_ON:  prdata = 32'(r_cfg.count_on);
            REG_COUNT_LIM: prdata = 32'(r_cfg.count_lim);
            REG_BYTE_ON:   prdata = 32'(r_cfg.byte_on);
            REG_BYTE_LIM:  prdata = 32'(r_cfg.byte_lim);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/pfpb_ctrl.sv
module pfpb_ctrl
    import pfpb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_req_type,
    input  t_status    i_status,
    output t_cmd       o_cmd,
    output logic       o_in_stall
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_req_type) inside
                        REQ_ENQUEUE: begin
                            n_state = i_status.full ? ST_PRE_RD : ST_APPEND;
                        end
                        REQ_RELEASE, REQ_DROP: begin
                            o_cmd.scan_init = 1'b1;
                            n_state         = ST_FL_RD;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_PRE_RD: begin
                n_state = ST_PRE_TAKE;
            end
            ST_PRE_TAKE: begin
                if (i_status.take_ok) begin
                    o_cmd.evict_take = 1'b1;
                    n_state          = ST_APPEND;
                end
            end
            ST_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_status.over ? ST_EV_RD : ST_DONE;
            end
            ST_EV_RD: begin
                n_state = ST_EV_TAKE;
            end
            ST_EV_TAKE: begin
                if (i_status.take_ok) begin
                    o_cmd.evict_take = 1'b1;
                    n_state          = ST_CHECK;
                end
            end
            ST_FL_RD: begin
                o_cmd.sel_scan = 1'b1;
                n_state        = i_status.scan_done ? ST_FL_END : ST_FL_CHK;
            end
            ST_FL_CHK: begin
                o_cmd.sel_scan = 1'b1;
                if (!i_status.match) begin
                    o_cmd.scan_keep = 1'b1;
                    o_cmd.scan_next = 1'b1;
                    n_state         = ST_FL_RD;
                end else if (i_status.take_ok) begin
                    o_cmd.scan_match = 1'b1;
                    o_cmd.scan_next  = 1'b1;
                    n_state          = ST_FL_RD;
                end
            end
            ST_FL_END: begin
                o_cmd.scan_end = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                // The held-back result is the final one of this request.
                if (!i_status.pend_v) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.flush_out = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> sv/pfpb_dp.sv
module pfpb_dp
    import pfpb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  t_cfg              i_cfg,
    output t_status           o_status,
    input  logic [1:0]        i_req_type,
    input  logic [15:0]       i_packet_handle,
    input  logic [15:0]       i_packet_bytes,
    input  logic [31:0]       i_dest_addr,
    input  logic [5:0]        i_prefix_len,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [1:0]        o_disposition,
    output logic [15:0]       o_out_handle,
    output logic [31:0]       o_out_dest,
    output logic [4:0]        o_send_slot,
    output logic              o_last
);

    function automatic t_ptr ptr_inc(input t_ptr p);
        ptr_inc = (p == t_ptr'(DEPTH - 1)) ? '0 : p + t_ptr'(1);
    endfunction

    t_ptr              r_head, r_tail, r_scan_ptr, r_wr_ptr;
    t_cnt              r_count, r_scan_idx, r_keep;
    logic [TOT_W-1:0]  r_total;
    logic [SLOT_W-1:0] r_slot;

    logic [1:0]        r_req;
    t_entry            r_ent;
    logic [ADDR_W-1:0] r_mask;

    logic              r_pend_v;
    logic [1:0]        r_pend_disp;
    logic [HB_W-1:0]   r_pend_handle;
    logic [ADDR_W-1:0] r_pend_dest;
    logic [SLOT_W-1:0] r_pend_slot;

    logic              r_out_v;
    logic [1:0]        r_out_disp;
    logic [15:0]       r_out_handle;
    logic [31:0]       r_out_dest;
    logic [SLOT_W-1:0] r_out_slot;
    logic              r_out_last;

    logic [5:0]        w_plen;
    logic [ENT_W-1:0]  w_rdata;
    t_entry            w_rd;
    logic              w_we;
    t_ptr              w_waddr, w_raddr;
    t_entry            w_wdata;
    logic              w_release;
    logic              w_take;
    logic              w_out_free;
    logic              w_cnt_over, w_byte_over;

    pfpb_ram #(
        .WIDTH(ENT_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd    = t_entry'(w_rdata);
    assign w_raddr = i_cmd.sel_scan ? r_scan_ptr : r_head;
    assign w_we    = i_cmd.append || i_cmd.scan_keep;
    assign w_waddr = i_cmd.append ? r_tail : r_wr_ptr;
    assign w_wdata = i_cmd.append ? r_ent : w_rd;

    assign w_plen     = (i_prefix_len > 6'd32) ? 6'd32 : i_prefix_len;
    assign w_release  = (r_req == REQ_RELEASE);
    assign w_take     = i_cmd.evict_take || i_cmd.scan_match;
    assign w_out_free = !r_out_v || !i_out_stall;

    assign w_cnt_over  = i_cfg.count_on &&
                         (CCMP_W'(r_count) > CCMP_W'(i_cfg.count_lim));
    assign w_byte_over = i_cfg.byte_on &&
                         (BCMP_W'(r_total) > BCMP_W'(i_cfg.byte_lim));

    always_comb begin
        o_status.count     = r_count;
        o_status.full      = (r_count == t_cnt'(DEPTH));
        o_status.over      = (r_count != '0) && (w_cnt_over || w_byte_over);
        o_status.scan_done = (r_scan_idx == r_count);
        o_status.match     = ((w_rd.dest ^ r_ent.dest) & r_mask) == '0;
        o_status.take_ok   = !r_pend_v || w_out_free;
        o_status.out_free  = w_out_free;
        o_status.pend_v    = r_pend_v;
    end

    // Request latch and the mask built from the clamped prefix length.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req        <= i_req_type;
            r_ent.handle <= i_packet_handle[HB_W-1:0];
            r_ent.dest   <= i_dest_addr;
            r_ent.len    <= i_packet_bytes;
            r_mask       <= ~(32'hFFFF_FFFF >> w_plen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_total    <= '0;
            r_scan_ptr <= '0;
            r_scan_idx <= '0;
            r_wr_ptr   <= '0;
            r_keep     <= '0;
            r_slot     <= '0;
        end else begin
            if (i_cmd.evict_take) begin
                r_head  <= ptr_inc(r_head);
                r_count <= r_count - t_cnt'(1);
                r_total <= r_total - TOT_W'(w_rd.len);
            end
            if (i_cmd.append) begin
                r_tail  <= ptr_inc(r_tail);
                r_count <= r_count + t_cnt'(1);
                r_total <= r_total + TOT_W'(r_ent.len);
            end
            if (i_cmd.scan_init) begin
                r_scan_ptr <= r_head;
                r_scan_idx <= '0;
                r_wr_ptr   <= r_head;
                r_keep     <= '0;
                r_slot     <= '0;
            end
            if (i_cmd.scan_match) begin
                r_total <= r_total - TOT_W'(w_rd.len);
                if (w_release) begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
            end
            if (i_cmd.scan_keep) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
                r_keep   <= r_keep + t_cnt'(1);
            end
            if (i_cmd.scan_next) begin
                r_scan_ptr <= ptr_inc(r_scan_ptr);
                r_scan_idx <= r_scan_idx + t_cnt'(1);
            end
            if (i_cmd.scan_end) begin
                r_count <= r_keep;
                r_tail  <= r_wr_ptr;
            end
        end
    end

    // One result is held back until the next one, or the end of the request,
    // shows whether it is the final one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (w_take) begin
            r_pend_v <= 1'b1;
        end else if (i_cmd.flush_out) begin
            r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_pend_handle <= w_rd.handle;
            r_pend_dest   <= w_rd.dest;
            if (i_cmd.evict_take) begin
                r_pend_disp <= DISP_FORCED;
                r_pend_slot <= '0;
            end else begin
                r_pend_disp <= w_release ? DISP_RELEASED : DISP_DROPPED;
                r_pend_slot <= w_release ? r_slot : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if ((w_take && r_pend_v) || i_cmd.flush_out) begin
            r_out_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_take && r_pend_v) || i_cmd.flush_out) begin
            r_out_disp   <= r_pend_disp;
            r_out_handle <= 16'(r_pend_handle);
            r_out_dest   <= r_pend_dest;
            r_out_slot   <= r_pend_slot;
            r_out_last   <= i_cmd.flush_out;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_disposition = r_out_disp;
    assign o_out_handle  = r_out_handle;
    assign o_out_dest    = r_out_dest;
    assign o_send_slot   = r_out_slot;
    assign o_last        = r_out_last;

endmodule

>>> sv/prefix_flush_packet_buffer.sv
// Channel    Direction  Handshake               Payload
// request    in         i_in_valid / o_in_stall  req_type, handle, bytes, dest, prefix
// result     out        o_out_valid / i_out_stall disposition, handle, dest, slot, last
// config     in         APB write / read         four limit registers
//
// An enqueue evicts the head first when full, appends, then evicts while a limit is exceeded.
// A flush visits each stored entry with a read state and a check state, set by the single
// read port of the entry memory and its registered read.
// Reset is synchronous and active low; it empties the buffer and loads the limit
// defaults. The entry memory itself is not cleared.
// A stall on the result side holds the sequencer once its one-deep hold stage
// and the output register are both occupied; requests are taken only when idle.
module prefix_flush_packet_buffer
    import pfpb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_packet_handle,
    input  logic [15:0] i_packet_bytes,
    input  logic [31:0] i_dest_addr,
    input  logic [5:0]  i_prefix_len,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_disposition,
    output logic [15:0] o_out_handle,
    output logic [31:0] o_out_dest,
    output logic [4:0]  o_send_slot,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    pfpb_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (w_cfg)
    );

    pfpb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .i_req_type(i_req_type),
        .i_status  (w_status),
        .o_cmd     (w_cmd),
        .o_in_stall(o_in_stall)
    );

    pfpb_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_cfg          (w_cfg),
        .o_status       (w_status),
        .i_req_type     (i_req_type),
        .i_packet_handle(i_packet_handle),
        .i_packet_bytes (i_packet_bytes),
        .i_dest_addr    (i_dest_addr),
        .i_prefix_len   (i_prefix_len),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_disposition  (o_disposition),
        .o_out_handle   (o_out_handle),
        .o_out_dest     (o_out_dest),
        .o_send_slot    (o_send_slot),
        .o_last         (o_last)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request taken while the previous one was still in work");

    a_idle_nothing_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !w_status.pend_v)
        else $error("idle with a result still held back");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.count <= t_cnt'(DEPTH))
        else $error("entry count above buffer depth");

    a_slot_only_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_disposition != DISP_RELEASED)) |-> (o_send_slot == '0))
        else $error("send slot set on a result that is not a release");

endmodule
